// ===== rtl/gcpp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcpp_pkg: shared definitions for the closest prime pair unit
// Widths, limits and the sequencer state type used by the interfaces and
// by the top level.
// ----------------------------------------------------------------------------
package gcpp_pkg;

	// Width of the number to split and of each prime in the result.
	localparam int TGT_W = 14;

	// Exclusive upper bound on the number to split.
	localparam int VALUE_LIMIT = 16384;

	// Trial divisor: it runs up to the first d with d*d above the candidate.
	localparam int DIV_W = TGT_W / 2 + 1;
	localparam int SQ_W  = 2 * DIV_W;
	// Partial remainder of the shift-subtract step holds up to 2d - 1.
	localparam int REM_W = DIV_W + 1;
	// Counts the bits of the candidate fed into the divider.
	localparam int CNT_W = $clog2(TGT_W);

	typedef logic [TGT_W-1:0] value_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/gcpp_query_if.sv =====
// ----------------------------------------------------------------------------
// gcpp_query_if: request channel of the closest prime pair unit
// Carries the number to be split, with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface gcpp_query_if;
	logic            valid;
	logic            ready;
	gcpp_pkg::value_t target;

	modport source (output valid, output target, input ready);
	modport sink   (input valid, input target, output ready);
endinterface

// ===== rtl/gcpp_result_if.sv =====
// ----------------------------------------------------------------------------
// gcpp_result_if: response channel of the closest prime pair unit
// Carries the prime pair and its found flag, with a valid and ready handshake.
// ----------------------------------------------------------------------------
interface gcpp_result_if;
	logic             valid;
	logic             ready;
	gcpp_pkg::value_t smaller_prime;
	gcpp_pkg::value_t larger_prime;
	logic             found;

	modport source (output valid, output smaller_prime, output larger_prime,
		output found, input ready);
	modport sink   (input valid, input smaller_prime, input larger_prime,
		input found, output ready);
endinterface

// ===== rtl/goldbach_closest_prime_pair_unit.sv =====
// ----------------------------------------------------------------------------
// goldbach_closest_prime_pair_unit: closest Goldbach prime pair finder
// Splits n into primes p <= q with p + q = n and the smallest q - p.
// ----------------------------------------------------------------------------
// Usage: a word on the query channel carries n. The unit scans p downward
// from n/2 and tests p, then n - p, for primality by trial division. The
// first p for which both are prime gives the answer on the result channel.
// If there is no pair (n below 4, or no p qualifies) the word carries zeros
// with found low.
// Timing: one query is worked on at a time and query.ready is high only
// while the sequencer is idle. Each trial divisor takes a pass through the
// check state and then through the shared remainder unit, which takes one
// bit of the candidate per cycle; a query repeats this for every divisor of
// every candidate tried. After the last test the sequencer moves to the
// finish state, which loads the output register as soon as it is free.
// Stalls: the result sits in an output register; a new query is taken as
// soon as that register has been loaded, even while the receiver stalls.
// A second finished answer waits in the sequencer until the register frees.
// Reset: arst_n clears the sequencer and the output valid flag at once.
// ----------------------------------------------------------------------------
module goldbach_closest_prime_pair_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	gcpp_query_if.sink            query,
	gcpp_result_if.source         result
);

	gcpp_pkg::state_t state_q, state_d;

	gcpp_pkg::value_t                 n_q;
	gcpp_pkg::value_t                 p_q;
	gcpp_pkg::value_t                 c_q;
	logic                             is_q_q;
	logic                             found_q;
	logic [gcpp_pkg::DIV_W-1:0]       d_q;
	logic [gcpp_pkg::SQ_W-1:0]        sq_q;
	logic [gcpp_pkg::REM_W-1:0]       rem_q;
	logic [gcpp_pkg::CNT_W-1:0]       cnt_q;

	gcpp_pkg::value_t                 smaller_q;
	gcpp_pkg::value_t                 larger_q;
	logic                             out_found_q;
	logic                             out_valid_q;

	logic                             accept;
	logic                             too_small;
	logic                             prime_done;
	logic                             div_last;
	logic                             load_out;
	logic [gcpp_pkg::CNT_W-1:0]       bit_idx;
	logic [gcpp_pkg::REM_W-1:0]       r_shift;
	logic [gcpp_pkg::REM_W-1:0]       r_next;
	logic [gcpp_pkg::REM_W-1:0]       d_ext;

	assign query.ready = (state_q == gcpp_pkg::ST_IDLE);
	assign accept      = query.valid && query.ready;
	assign too_small   = (query.target < gcpp_pkg::TGT_W'(4))
		|| (32'(query.target) >= 32'(gcpp_pkg::VALUE_LIMIT));

	// All trial divisors up to the square root have been tried.
	assign prime_done  = sq_q > gcpp_pkg::SQ_W'(c_q);

	// Shared remainder unit: one bit of the candidate per cycle, MSB first.
	assign bit_idx  = gcpp_pkg::CNT_W'(gcpp_pkg::TGT_W - 1) - cnt_q;
	assign d_ext    = gcpp_pkg::REM_W'(d_q);
	assign r_shift  = {rem_q[gcpp_pkg::REM_W-2:0], c_q[bit_idx]};
	assign r_next   = (r_shift >= d_ext) ? (r_shift - d_ext) : r_shift;
	assign div_last = (cnt_q == gcpp_pkg::CNT_W'(gcpp_pkg::TGT_W - 1));

	assign load_out = (state_q == gcpp_pkg::ST_FINISH) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gcpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gcpp_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = too_small ? gcpp_pkg::ST_FINISH : gcpp_pkg::ST_CHECK;
				end
			end
			gcpp_pkg::ST_CHECK: begin
				if (!prime_done) begin
					state_d = gcpp_pkg::ST_DIV;
				end else if (is_q_q) begin
					state_d = gcpp_pkg::ST_FINISH;
				end
			end
			gcpp_pkg::ST_DIV: begin
				if (div_last) begin
					if (r_next == '0 && p_q == gcpp_pkg::TGT_W'(2)) begin
						state_d = gcpp_pkg::ST_FINISH;
					end else begin
						state_d = gcpp_pkg::ST_CHECK;
					end
				end
			end
			gcpp_pkg::ST_FINISH: begin
				if (load_out) begin
					state_d = gcpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = gcpp_pkg::ST_IDLE;
			end
		endcase
	end

	// Candidate and divider datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			gcpp_pkg::ST_IDLE: begin
				if (accept) begin
					n_q     <= query.target;
					p_q     <= query.target >> 1;
					c_q     <= query.target >> 1;
					is_q_q  <= 1'b0;
					found_q <= 1'b0;
					d_q     <= gcpp_pkg::DIV_W'(2);
					sq_q    <= gcpp_pkg::SQ_W'(4);
				end
			end
			gcpp_pkg::ST_CHECK: begin
				if (prime_done) begin
					if (!is_q_q) begin
						// p is prime, so go on to test its partner n - p.
						c_q    <= n_q - p_q;
						is_q_q <= 1'b1;
						d_q    <= gcpp_pkg::DIV_W'(2);
						sq_q   <= gcpp_pkg::SQ_W'(4);
					end else begin
						found_q <= 1'b1;
					end
				end else begin
					rem_q <= '0;
					cnt_q <= '0;
				end
			end
			gcpp_pkg::ST_DIV: begin
				rem_q <= r_next;
				cnt_q <= cnt_q + gcpp_pkg::CNT_W'(1);
				if (div_last) begin
					if (r_next == '0) begin
						// Composite: step down to the next smaller p.
						p_q    <= p_q - gcpp_pkg::TGT_W'(1);
						c_q    <= p_q - gcpp_pkg::TGT_W'(1);
						is_q_q <= 1'b0;
						d_q    <= gcpp_pkg::DIV_W'(2);
						sq_q   <= gcpp_pkg::SQ_W'(4);
					end else begin
						// (d + 1)^2 = d^2 + 2d + 1
						d_q  <= d_q + gcpp_pkg::DIV_W'(1);
						sq_q <= sq_q + gcpp_pkg::SQ_W'({d_q, 1'b1});
					end
				end
			end
			gcpp_pkg::ST_FINISH: begin
				if (load_out) begin
					smaller_q   <= found_q ? p_q : '0;
					larger_q    <= found_q ? (n_q - p_q) : '0;
					out_found_q <= found_q;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.smaller_prime = smaller_q;
	assign result.larger_prime  = larger_q;
	assign result.found         = out_found_q;

	// The running square must track the trial divisor.
	a_square_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcpp_pkg::ST_CHECK) |->
			(32'(sq_q) == 32'(d_q) * 32'(d_q)))
		else $error("running square does not match the trial divisor");

	// The partial remainder stays below the divisor throughout a division.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gcpp_pkg::ST_DIV) |-> (rem_q < d_ext))
		else $error("partial remainder reached the divisor");

	// A found pair is ordered and its smaller member is at least two.
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.found) |->
			(result.smaller_prime <= result.larger_prime
			&& result.smaller_prime >= gcpp_pkg::TGT_W'(2)))
		else $error("found pair is out of order");

	// No pair means zero primes on the result word.
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.found) |->
			(result.smaller_prime == '0 && result.larger_prime == '0))
		else $error("no-pair result carries non-zero primes");

	// The output register is only loaded when it is free or being emptied.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> ($stable(smaller_q) && $stable(larger_q)))
		else $error("stalled result word was overwritten");

endmodule

// ===== sim/goldbach_closest_prime_pair_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// goldbach_closest_prime_pair_unit_test: testbench of the closest pair unit
// Sends numbers on the query channel and checks every result word against
// a trial-division predictor kept in the testbench. Directed numbers come
// first, then random ones under changing sender and receiver stalls.
// ----------------------------------------------------------------------------
module goldbach_closest_prime_pair_unit_test;

	typedef struct packed {
		gcpp_pkg::value_t smaller;
		gcpp_pkg::value_t larger;
		logic             found;
	} prime_pair_t;

	logic clk;
	logic arst_n;

	gcpp_query_if  query_bus ();
	gcpp_result_if result_bus ();

	goldbach_closest_prime_pair_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query_bus),
		.result (result_bus)
	);

	prime_pair_t pair_queue[$];
	prime_pair_t oldest_pair;
	int          errors;
	int          send_idle_pct;
	int          recv_idle_pct;

	always #1 clk = ~clk;

	function automatic bit is_prime_number(input int c);
		if (c < 2)
			return 1'b0;
		for (int d = 2; d * d <= c; d++) begin
			if (c % d == 0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// The first p downward from n/2 with both p and n - p prime gives the
	// smallest difference, since n - 2p grows as p falls.
	function automatic prime_pair_t closest_prime_pair(input gcpp_pkg::value_t n);
		prime_pair_t pair;
		int          total;
		pair  = '0;
		total = int'(n);
		if (total >= gcpp_pkg::VALUE_LIMIT || total < 4)
			return pair;
		for (int p = total / 2; p >= 2; p--) begin
			if (is_prime_number(p) && is_prime_number(total - p)) begin
				pair.smaller = gcpp_pkg::value_t'(p);
				pair.larger  = gcpp_pkg::value_t'(total - p);
				pair.found   = 1'b1;
				return pair;
			end
		end
		return pair;
	endfunction

	// Odd numbers make the unit scan every p down to 2, so they stay small.
	function automatic gcpp_pkg::value_t random_target();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 4)
			return gcpp_pkg::value_t'(2 * $urandom_range(0, 511));
		else if (sel < 6)
			return gcpp_pkg::value_t'($urandom_range(0, 255));
		else if (sel < 7)
			return gcpp_pkg::value_t'($urandom_range(0, 15));
		else if (sel < 8)
			return gcpp_pkg::value_t'(2 * $urandom_range(0, 511) + 1);
		else
			return gcpp_pkg::value_t'(2 * $urandom_range(512, 8191));
	endfunction

	task automatic send_target(input gcpp_pkg::value_t n);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			query_bus.valid <= 1'b0;
			@(posedge clk);
		end
		query_bus.valid  <= 1'b1;
		query_bus.target <= n;
		do
			@(posedge clk);
		while (!query_bus.ready);
		pair_queue.push_back(closest_prime_pair(n));
	endtask

	task automatic wait_for_results();
		query_bus.valid <= 1'b0;
		while (pair_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_small_and_extreme_targets();
		gcpp_pkg::value_t targets[$];
		// Below four, the smallest pairs, odd numbers with and without a
		// pair, single high bit and both ends of the range.
		targets = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 11, 12, 23, 27, 35, 98, 100,
			128, 1001, 8192, 16380, 16382, 16383};
		foreach (targets[k])
			send_target(targets[k]);
	endtask

	task automatic test_random_targets(input int count);
		for (int k = 0; k < count; k++)
			send_target(random_target());
	endtask

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (pair_queue.size() == 0) begin
				$display("%0t: unexpected result word: smaller %0d larger %0d found %0b",
					$time, result_bus.smaller_prime, result_bus.larger_prime,
					result_bus.found);
				errors++;
			end else begin
				oldest_pair = pair_queue.pop_front();
				if (result_bus.smaller_prime !== oldest_pair.smaller) begin
					$display("%0t: smaller_prime expected %0d actual %0d", $time,
						oldest_pair.smaller, result_bus.smaller_prime);
					errors++;
				end
				if (result_bus.larger_prime !== oldest_pair.larger) begin
					$display("%0t: larger_prime expected %0d actual %0d", $time,
						oldest_pair.larger, result_bus.larger_prime);
					errors++;
				end
				if (result_bus.found !== oldest_pair.found) begin
					$display("%0t: found expected %0b actual %0b", $time,
						oldest_pair.found, result_bus.found);
					errors++;
				end
			end
		end
		result_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		clk              = 1'b0;
		arst_n           = 1'b0;
		errors           = 0;
		send_idle_pct    = 26;
		recv_idle_pct    = 85;
		query_bus.valid  <= 1'b0;
		query_bus.target <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_small_and_extreme_targets();
		// Hold the sender back until the unit has emptied completely.
		wait_for_results();
		test_random_targets(40);
		wait_for_results();

		send_idle_pct = 85;
		recv_idle_pct = 26;
		test_random_targets(40);
		wait_for_results();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_targets(40);
		wait_for_results();

		// Give a stray extra word time to show up.
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("[goldbach_closest_prime_pair_unit] OK");
		else
			$display("[goldbach_closest_prime_pair_unit] ERROR");
		$finish;
	end

	initial begin
		#200_000_000;
		$display("[goldbach_closest_prime_pair_unit] ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/gcpp_pkg.sv
rtl/gcpp_query_if.sv
rtl/gcpp_result_if.sv
rtl/goldbach_closest_prime_pair_unit.sv
sim/goldbach_closest_prime_pair_unit_test.sv
